### design/slsp_pkg.sv
// slsp_pkg: shared constants and types for the switch and led panel controller
// no dependencies
`timescale 1ns / 1ps

package slsp_pkg;

    // switch sample ring
    localparam int SAMPLE_DEPTH = 5;
    localparam int RING_IDX_W   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    // field and register widths
    localparam int HB_W      = 10;
    localparam int SP_W      = 6;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 3;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 32;

    // register reset values
    localparam logic [HB_W-1:0] HB_PERIOD_RST = HB_W'(1000);
    localparam logic [SP_W-1:0] SP_PERIOD_RST = SP_W'(25);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD    = 1'b1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RX_FRAME  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEND_DONE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEND_ERR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POLL      = 3'd4;

    // frame characters
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
    localparam logic [BYTE_W-1:0] CH_8      = 8'h38;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;

    // status byte bits
    localparam int ST_LED_A_BIT   = 0;
    localparam int ST_LED_B_BIT   = 1;
    localparam int ST_PRESSED_BIT = 2;

    // send phase codes
    typedef logic [2:0] phase_t;
    localparam phase_t PH_IDLE         = 3'd0;
    localparam phase_t PH_PRESS_BUSY   = 3'd1;
    localparam phase_t PH_PRESS_DONE   = 3'd2;
    localparam phase_t PH_RELEASE_BUSY = 3'd3;
    localparam phase_t PH_STATUS_BUSY  = 3'd4;

endpackage

### design/switch_led_serial_panel_unit.sv
// switch_led_serial_panel_unit: panel controller with heartbeat, switch debounce,
// led toggle commands and press/release/status frames
// depends on slsp_pkg
`timescale 1ns / 1ps

// the result word is registered: it appears in the cycle after its input word is accepted
// throughput: one word per cycle unless m_tready stalls the result register
// s_tready stays high while the result register is empty or being taken
// reset (aresetn low, synchronous): periods 1000 and 25, counters, ring,
// debounce state, leds and send phase cleared, result register empty

module switch_led_serial_panel_unit
    import slsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // switch_level[0], rx_first[8:1], rx_middle[16:9], rx_last[24:17], zero fill
    input  logic [S_DATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]     s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // heartbeat_led[0], led_a[1], led_b[2], send_frame[3], send_first[11:4],
    // send_middle[19:12], send_last[27:20], switch_pressed[28], zero fill
    output logic [M_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [HB_W-1:0]         hb_period_reg;
    logic [SP_W-1:0]         sp_period_reg;
    phase_t                  send_phase_reg, send_phase_next;
    phase_t                  saved_phase_reg, saved_phase_next;
    logic [HB_W-1:0]         hb_count_reg, hb_count_next;
    logic [SP_W-1:0]         sp_count_reg, sp_count_next;
    logic [SAMPLE_DEPTH-1:0] ring_reg, ring_next;
    logic [RING_IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic                    deb_high_reg, deb_high_next;
    logic [2:0]              led_reg, led_next;
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                    s_accept;
    logic [REQ_W-1:0]        req_type;
    logic                    switch_level;
    logic [BYTE_W-1:0]       rx_first, rx_middle, rx_last;
    logic                    frame_ok;
    logic                    deb_upd;
    logic [HB_W:0]           hb_inc;
    logic [SP_W:0]           sp_inc;
    logic [RING_IDX_W:0]     idx_inc;
    logic                    send;
    logic [BYTE_W-1:0]       s1;

    assign req_type     = s_tuser;
    assign switch_level = s_tdata[0];
    assign rx_first     = s_tdata[8:1];
    assign rx_middle    = s_tdata[16:9];
    assign rx_last      = s_tdata[24:17];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign frame_ok = (rx_first == CH_HASH) && (rx_last == CH_DOLLAR);
    // state flips only when every sample disagrees with it
    assign deb_upd  = deb_high_reg ? (|ring_reg) : (&ring_reg);
    assign hb_inc   = {1'b0, hb_count_reg} + (HB_W+1)'(1);
    assign sp_inc   = {1'b0, sp_count_reg} + (SP_W+1)'(1);
    assign idx_inc  = {1'b0, ring_idx_reg} + (RING_IDX_W+1)'(1);

    always_comb begin
        send_phase_next  = send_phase_reg;
        saved_phase_next = saved_phase_reg;
        hb_count_next    = hb_count_reg;
        sp_count_next    = sp_count_reg;
        ring_next        = ring_reg;
        ring_idx_next    = ring_idx_reg;
        deb_high_next    = deb_high_reg;
        led_next         = led_reg;
        send             = 1'b0;
        s1               = '0;

        case (req_type)
            REQ_TICK: begin
                if (hb_count_reg == '0) begin
                    led_next[0] = ~led_reg[0];
                end
                if (hb_inc >= {1'b0, hb_period_reg}) begin
                    hb_count_next = '0;
                end else begin
                    hb_count_next = hb_inc[HB_W-1:0];
                end
                if (sp_count_reg == '0) begin
                    ring_next[ring_idx_reg] = switch_level;
                    if (idx_inc >= (RING_IDX_W+1)'(SAMPLE_DEPTH)) begin
                        ring_idx_next = '0;
                    end else begin
                        ring_idx_next = idx_inc[RING_IDX_W-1:0];
                    end
                end
                if (sp_inc >= {1'b0, sp_period_reg}) begin
                    sp_count_next = '0;
                end else begin
                    sp_count_next = sp_inc[SP_W-1:0];
                end
            end
            REQ_RX_FRAME: begin
                if (frame_ok) begin
                    if (rx_middle == CH_8) begin
                        led_next[1] = ~led_reg[1];
                    end else if (rx_middle == CH_9) begin
                        led_next[2] = ~led_reg[2];
                    end else if (rx_middle == CH_S) begin
                        deb_high_next        = deb_upd;
                        s1[ST_PRESSED_BIT]   = ~deb_upd;
                        s1[ST_LED_A_BIT]     = led_reg[1];
                        s1[ST_LED_B_BIT]     = led_reg[2];
                        if (send_phase_reg != PH_STATUS_BUSY) begin
                            saved_phase_next = send_phase_reg;
                        end
                        send_phase_next = PH_STATUS_BUSY;
                        send            = 1'b1;
                    end
                end
            end
            REQ_SEND_DONE: begin
                if (send_phase_reg == PH_PRESS_BUSY) begin
                    send_phase_next = PH_PRESS_DONE;
                end else if (send_phase_reg == PH_RELEASE_BUSY) begin
                    send_phase_next = PH_IDLE;
                end else if (send_phase_reg == PH_STATUS_BUSY) begin
                    send_phase_next = saved_phase_reg;
                end
            end
            REQ_POLL: begin
                deb_high_next = deb_upd;
                if (!deb_upd) begin
                    if (send_phase_reg == PH_IDLE) begin
                        send_phase_next = PH_PRESS_BUSY;
                        s1              = CH_P;
                        send            = 1'b1;
                    end
                end else if (send_phase_reg == PH_PRESS_DONE) begin
                    send_phase_next = PH_RELEASE_BUSY;
                    s1              = CH_R;
                    send            = 1'b1;
                end
            end
            default: begin
                // send error and unused codes leave the state alone
            end
        endcase

        m_tdata_next        = '0;
        m_tdata_next[0]     = led_next[0];
        m_tdata_next[1]     = led_next[1];
        m_tdata_next[2]     = led_next[2];
        m_tdata_next[3]     = send;
        m_tdata_next[11:4]  = send ? CH_HASH : '0;
        m_tdata_next[19:12] = send ? s1 : '0;
        m_tdata_next[27:20] = send ? CH_DOLLAR : '0;
        m_tdata_next[28]    = ~deb_high_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_period_reg <= HB_PERIOD_RST;
            sp_period_reg <= SP_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEARTBEAT_PERIOD: hb_period_reg <= cfg_wdata[HB_W-1:0];
                REG_SAMPLE_PERIOD:    sp_period_reg <= cfg_wdata[SP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_phase_reg  <= PH_IDLE;
            saved_phase_reg <= PH_IDLE;
            hb_count_reg    <= '0;
            sp_count_reg    <= '0;
            ring_reg        <= '0;
            ring_idx_reg    <= '0;
            deb_high_reg    <= 1'b0;
            led_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                send_phase_reg  <= send_phase_next;
                saved_phase_reg <= saved_phase_next;
                hb_count_reg    <= hb_count_next;
                sp_count_reg    <= sp_count_next;
                ring_reg        <= ring_next;
                ring_idx_reg    <= ring_idx_next;
                deb_high_reg    <= deb_high_next;
                led_reg         <= led_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // result word mirrors the state it leaves behind
    a_led_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata[2:0] == led_reg) && (m_tdata[28] == !deb_high_reg))
        else $error("result leds or pressed flag differ from stored state");

    // a frame word always carries the frame delimiters
    a_frame_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[11:4] == CH_HASH) &&
                                     (m_tdata[27:20] == CH_DOLLAR))
        else $error("sent frame without delimiters");

    // any frame sent leaves a send in flight
    a_send_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && send) |=> (send_phase_reg == PH_PRESS_BUSY ||
                                send_phase_reg == PH_RELEASE_BUSY ||
                                send_phase_reg == PH_STATUS_BUSY))
        else $error("frame sent without a busy send phase");

    // a status send saves the phase it interrupted, never the status phase
    a_saved_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (send_phase_reg == PH_STATUS_BUSY) |-> (saved_phase_reg != PH_STATUS_BUSY))
        else $error("saved phase is the status phase");

endmodule

### bench/switch_led_serial_panel_unit_tb.sv
// switch_led_serial_panel_unit_tb: self-checking bench for the panel controller
// predicts every result word in-bench from the accepted input words and the register writes
// depends on slsp_pkg and switch_led_serial_panel_unit
`timescale 1ns / 1ps

module switch_led_serial_panel_unit_tb;
    import slsp_pkg::*;

    typedef struct {
        logic              hb;
        logic              led_a;
        logic              led_b;
        logic              send;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] middle;
        logic [BYTE_W-1:0] last;
        logic              pressed;
    } panel_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    // panel state as predicted
    logic [HB_W-1:0] hb_period_m;
    logic [SP_W-1:0] sp_period_m;
    phase_t          phase_m;
    phase_t          saved_m;
    logic [HB_W-1:0] hb_cnt_m;
    logic [SP_W-1:0] sp_cnt_m;
    logic            ring_m [SAMPLE_DEPTH];
    int              ring_idx_m;
    logic            deb_high_m;
    logic [2:0]      leds_m;

    panel_word_t panel_words_due [$];
    int          mismatch_count = 0;
    int          words_sent     = 0;
    int          words_seen     = 0;
    int          press_frames   = 0;
    int          release_frames = 0;
    int          status_frames  = 0;
    int          debounce_flips = 0;
    bit          no_gaps        = 1'b0;
    bit          no_stalls      = 1'b0;
    int          ready_hold     = 0;

    switch_led_serial_panel_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int wrap_next(int count, int period);
        int nxt;
        nxt = count + 1;
        if (period == 0 || nxt >= period) return 0;
        return nxt;
    endfunction

    // hysteresis: change only when every sample agrees
    function automatic void settle_debounce();
        int ones;
        ones = 0;
        for (int i = 0; i < SAMPLE_DEPTH; i++) ones += ring_m[i];
        if (!deb_high_m && ones == SAMPLE_DEPTH) begin
            deb_high_m = 1'b1;
            debounce_flips++;
        end else if (deb_high_m && ones == 0) begin
            deb_high_m = 1'b0;
            debounce_flips++;
        end
    endfunction

    function automatic panel_word_t predict_panel_word(logic [REQ_W-1:0] req, logic level,
                                                       logic [BYTE_W-1:0] b0,
                                                       logic [BYTE_W-1:0] b1,
                                                       logic [BYTE_W-1:0] b2);
        panel_word_t       w;
        logic              send;
        logic [BYTE_W-1:0] mid;
        send = 1'b0;
        mid  = '0;
        case (req)
            REQ_TICK: begin
                if (hb_cnt_m == 0) leds_m[0] = ~leds_m[0];
                hb_cnt_m = HB_W'(wrap_next(hb_cnt_m, hb_period_m));
                if (sp_cnt_m == 0) begin
                    if (ring_idx_m >= SAMPLE_DEPTH) ring_idx_m = 0;
                    ring_m[ring_idx_m] = level;
                    ring_idx_m = wrap_next(ring_idx_m, SAMPLE_DEPTH);
                end
                sp_cnt_m = SP_W'(wrap_next(sp_cnt_m, sp_period_m));
            end
            REQ_RX_FRAME: begin
                if (b0 == CH_HASH && b2 == CH_DOLLAR) begin
                    if (b1 == CH_8) begin
                        leds_m[1] = ~leds_m[1];
                    end else if (b1 == CH_9) begin
                        leds_m[2] = ~leds_m[2];
                    end else if (b1 == CH_S) begin
                        settle_debounce();
                        mid[ST_PRESSED_BIT] = ~deb_high_m;
                        mid[ST_LED_A_BIT]   = leds_m[1];
                        mid[ST_LED_B_BIT]   = leds_m[2];
                        if (phase_m != PH_STATUS_BUSY) saved_m = phase_m;
                        phase_m = PH_STATUS_BUSY;
                        send = 1'b1;
                        status_frames++;
                    end
                end
            end
            REQ_SEND_DONE: begin
                if (phase_m == PH_PRESS_BUSY) phase_m = PH_PRESS_DONE;
                else if (phase_m == PH_RELEASE_BUSY) phase_m = PH_IDLE;
                else if (phase_m == PH_STATUS_BUSY) phase_m = saved_m;
            end
            REQ_POLL: begin
                settle_debounce();
                if (!deb_high_m) begin
                    if (phase_m == PH_IDLE) begin
                        phase_m = PH_PRESS_BUSY;
                        mid = CH_P;
                        send = 1'b1;
                        press_frames++;
                    end
                end else if (phase_m == PH_PRESS_DONE) begin
                    phase_m = PH_RELEASE_BUSY;
                    mid = CH_R;
                    send = 1'b1;
                    release_frames++;
                end
            end
            REQ_SEND_ERR: ;
            default: ;
        endcase
        w.hb      = leds_m[0];
        w.led_a   = leds_m[1];
        w.led_b   = leds_m[2];
        w.send    = send;
        w.first   = send ? CH_HASH : '0;
        w.middle  = send ? mid : '0;
        w.last    = send ? CH_DOLLAR : '0;
        w.pressed = ~deb_high_m;
        return w;
    endfunction

    task automatic send_word(logic [REQ_W-1:0] req, logic level, logic [BYTE_W-1:0] b0,
                             logic [BYTE_W-1:0] b1, logic [BYTE_W-1:0] b2);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_DATA_W'({b2, b1, b0, level});
        do @(posedge aclk); while (!s_tready);
        panel_words_due.push_back(predict_panel_word(req, level, b0, b1, b2));
        words_sent++;
    endtask

    // stop sending and let every expected word come back
    task automatic drain_panel();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (panel_words_due.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_HEARTBEAT_PERIOD) hb_period_m = value[HB_W-1:0];
        else sp_period_m = value[SP_W-1:0];
    endtask

    task automatic flag_field(string field, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR: result word %0d %s: expected %0h, got %0h",
                     words_seen, field, want, got);
    endtask

    always @(negedge aclk) begin : drive_ready
        int r;
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (no_stalls || r < 65) begin
                m_tready <= 1'b1;
                ready_hold = $urandom_range(0, 15);
            end else if (r < 94) begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge aclk) begin : check_words
        panel_word_t got;
        panel_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            got.hb      = m_tdata[0];
            got.led_a   = m_tdata[1];
            got.led_b   = m_tdata[2];
            got.send    = m_tdata[3];
            got.first   = m_tdata[11:4];
            got.middle  = m_tdata[19:12];
            got.last    = m_tdata[27:20];
            got.pressed = m_tdata[28];
            if (panel_words_due.size() == 0) begin
                flag_field("word with none outstanding", 0, m_tdata);
            end else begin
                want = panel_words_due.pop_front();
                if (got.hb !== want.hb) flag_field("heartbeat_led", want.hb, got.hb);
                if (got.led_a !== want.led_a) flag_field("led_a", want.led_a, got.led_a);
                if (got.led_b !== want.led_b) flag_field("led_b", want.led_b, got.led_b);
                if (got.send !== want.send) flag_field("send_frame", want.send, got.send);
                if (got.first !== want.first) flag_field("send_first", want.first, got.first);
                if (got.middle !== want.middle)
                    flag_field("send_middle", want.middle, got.middle);
                if (got.last !== want.last) flag_field("send_last", want.last, got.last);
                if (got.pressed !== want.pressed)
                    flag_field("switch_pressed", want.pressed, got.pressed);
            end
        end
    end

    // spurious completion, poll right after reset, send error and unknown requests
    task automatic test_after_reset();
        send_word(REQ_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_word(REQ_SEND_DONE, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_POLL, 1'b1, 8'h00, 8'h00, 8'h00);
        send_word(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_SEND_ERR, 1'b1, CH_HASH, CH_8, CH_DOLLAR);
        for (int k = REQ_POLL + 1; k < (1 << REQ_W); k++)
            send_word(REQ_W'(k), 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_word(REQ_SEND_DONE, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // led commands, status while busy, malformed frames
    task automatic test_frames();
        send_word(REQ_RX_FRAME, 1'b0, CH_HASH, CH_8, CH_DOLLAR);
        send_word(REQ_RX_FRAME, 1'b0, CH_HASH, CH_9, CH_DOLLAR);
        send_word(REQ_RX_FRAME, 1'b0, CH_HASH, CH_S, CH_DOLLAR);
        send_word(REQ_RX_FRAME, 1'b1, CH_HASH, CH_S, CH_DOLLAR);
        send_word(REQ_SEND_DONE, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_SEND_DONE, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_RX_FRAME, 1'b0, 8'h00, CH_8, CH_DOLLAR);
        send_word(REQ_RX_FRAME, 1'b0, CH_HASH, CH_9, 8'hFF);
        send_word(REQ_RX_FRAME, 1'b0, CH_HASH, 8'h58, CH_DOLLAR);
    endtask

    // release sent once after the switch settles high
    task automatic test_release_once();
        drain_panel();
        write_reg(REG_SAMPLE_PERIOD, CFG_W'(1));
        repeat (5) send_word(REQ_TICK, 1'b1, 8'h00, 8'h00, 8'h00);
        send_word(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_SEND_DONE, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_POLL, 1'b0, 8'h00, 8'h00, 8'h00);
    endtask

    // zero periods, largest periods, then periods lowered under the counters
    task automatic test_periods();
        drain_panel();
        write_reg(REG_HEARTBEAT_PERIOD, CFG_W'(0));
        write_reg(REG_SAMPLE_PERIOD, CFG_W'(0));
        repeat (6) send_word(REQ_TICK, 1'($urandom), 8'h00, 8'h00, 8'h00);
        drain_panel();
        write_reg(REG_HEARTBEAT_PERIOD, CFG_W'(1023));
        write_reg(REG_SAMPLE_PERIOD, CFG_W'(10'h3FF));
        repeat (200)
            send_word(REQ_TICK, 1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      BYTE_W'($urandom));
        drain_panel();
        write_reg(REG_HEARTBEAT_PERIOD, CFG_W'(5));
        write_reg(REG_SAMPLE_PERIOD, CFG_W'(3));
        repeat (10) send_word(REQ_TICK, 1'($urandom), 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random();
        int                hb_set [7] = '{1, 7, 1023, 2, 0, 300, 0};
        int                sp_set [7] = '{1, 2, 1, 3, 4, 63, 0};
        int                r;
        logic              pin;
        logic              level;
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] b0, b1, b2;
        pin = 1'b0;
        for (int p = 0; p < 7; p++) begin
            drain_panel();
            if (p == 6) begin
                hb_set[p] = $urandom_range(0, 1023);
                sp_set[p] = $urandom_range(0, 8);
            end
            write_reg(REG_HEARTBEAT_PERIOD, CFG_W'(hb_set[p]));
            write_reg(REG_SAMPLE_PERIOD, CFG_W'(sp_set[p]));
            no_gaps   = (p == 2);
            no_stalls = (p == 2);
            for (int n = 0; n < 200; n++) begin
                r     = $urandom_range(0, 99);
                b0    = BYTE_W'($urandom);
                b1    = BYTE_W'($urandom);
                b2    = BYTE_W'($urandom);
                level = 1'($urandom);
                if (r < 40) begin
                    req = REQ_TICK;
                    if ($urandom_range(0, 24) == 0) pin = ~pin;
                    level = ($urandom_range(0, 19) == 0) ? ~pin : pin;
                end else if (r < 55) begin
                    req = REQ_POLL;
                end else if (r < 68) begin
                    req = REQ_SEND_DONE;
                end else if (r < 85) begin
                    req = REQ_RX_FRAME;
                    b0  = CH_HASH;
                    b2  = CH_DOLLAR;
                    case ($urandom_range(0, 2))
                        0: b1 = CH_8;
                        1: b1 = CH_9;
                        default: b1 = CH_S;
                    endcase
                end else if (r < 90) begin
                    req = REQ_SEND_ERR;
                end else if (r < 96) begin
                    // broken frames, often with one end right
                    req = REQ_RX_FRAME;
                    if ($urandom_range(0, 1)) b0 = CH_HASH;
                    if ($urandom_range(0, 1)) b2 = CH_DOLLAR;
                end else begin
                    req = REQ_W'($urandom_range(REQ_POLL + 1, (1 << REQ_W) - 1));
                end
                send_word(req, level, b0, b1, b2);
            end
        end
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_TICK;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_HEARTBEAT_PERIOD;
        cfg_wdata = '0;

        hb_period_m = HB_PERIOD_RST;
        sp_period_m = SP_PERIOD_RST;
        phase_m     = PH_IDLE;
        saved_m     = PH_IDLE;
        hb_cnt_m    = '0;
        sp_cnt_m    = '0;
        ring_idx_m  = 0;
        deb_high_m  = 1'b0;
        leds_m      = '0;
        for (int i = 0; i < SAMPLE_DEPTH; i++) ring_m[i] = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_frames();
        test_release_once();
        test_periods();
        test_random();
        drain_panel();
        repeat (10) @(posedge aclk);

        if (panel_words_due.size() != 0) begin
            $display("ERROR: %0d result words never arrived", panel_words_due.size());
            mismatch_count += panel_words_due.size();
        end
        $display("covered %0d input words and %0d result words, %0d errors", words_sent,
                 words_seen, mismatch_count);
        $display("frames: %0d press, %0d release, %0d status; %0d debounce changes",
                 press_frames, release_frames, status_frames, debounce_flips);
        if (mismatch_count == 0) begin
            $display("switch_led_serial_panel_unit: match");
        end else begin
            $display("switch_led_serial_panel_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("ERROR: run did not finish in time");
        $display("switch_led_serial_panel_unit: mismatch");
        $finish;
    end

endmodule
